// ----- src/first_fit_extent_allocator_unit_defines.svh -----
// assertion macros used by the allocator rtl
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_UNIT_DEFINES_SVH

// checked outside reset
`define FFEA_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define FFEA_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/ffea_pkg.sv -----
// types and constants of the first-fit extent allocator
package ffea_pkg;

	localparam int PAGE_BITS  = 20;
	localparam int COUNT_BITS = 21;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	typedef struct packed {
		logic                  command;
		logic [PAGE_BITS-1:0]  page_index;
		logic [COUNT_BITS-1:0] page_count;
	} req_t;

	typedef struct packed {
		logic [1:0]            status;
		logic [PAGE_BITS-1:0]  result_page;
		logic [COUNT_BITS-1:0] free_total;
	} rsp_t;

	typedef struct packed {
		logic [PAGE_BITS-1:0]  start;
		logic [COUNT_BITS-1:0] length;
	} entry_t;

endpackage

// ----- src/first_fit_extent_allocator_unit.sv -----
// first-fit extent allocator: sorted free-extent table walked by a small sequencer
//
//  port     dir  kind     meaning
//  request  in   start    command, page_index, page_count; taken when start && !busy
//  result   out  done     status, result_page, free_total; valid for one cycle
//
// each request walks the table one entry at a time (ram read, then compare)
// remove and insert move the tail one entry at a time through the ram port (read, then write)
// a zero-count request goes straight to the done step; the longest requests are
// insert or remove near the front of a nearly full table
// reset empties the table at once (entry count to zero), no clearing pass
// the receiver cannot stall; done pulses one cycle and busy is already low then
`include "first_fit_extent_allocator_unit_defines.svh"

module first_fit_extent_allocator_unit #(
	parameter int MAX_EXTENTS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  ffea_pkg::req_t request,
	output logic           done,
	output ffea_pkg::rsp_t result
);

	localparam int AW    = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
	localparam int IW    = $clog2(MAX_EXTENTS + 1);
	localparam int PB    = ffea_pkg::PAGE_BITS;
	localparam int CB    = ffea_pkg::COUNT_BITS;
	localparam int SUM_W = CB + $clog2(MAX_EXTENTS);
	localparam int EW    = PB + CB;

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_SCAN_RD  = 8'b0000_0010,
		S_SCAN_CMP = 8'b0000_0100,
		S_MERGE    = 8'b0000_1000,
		S_PLACE    = 8'b0001_0000,
		S_SHIFT_RD = 8'b0010_0000,
		S_SHIFT_WR = 8'b0100_0000,
		S_DONE     = 8'b1000_0000
	} state_t;

	state_t              state_q;
	logic                cmd_q;
	logic [PB-1:0]       page_q;
	logic [CB-1:0]       cnt_q;
	logic [IW-1:0]       idx_q;
	logic [IW-1:0]       sidx_q;
	logic [IW-1:0]       used_q;
	logic [SUM_W-1:0]    sum_q;
	ffea_pkg::entry_t    prev_q;
	ffea_pkg::entry_t    cur_q;
	ffea_pkg::entry_t    new_q;
	logic                prev_ok_q;
	logic                cur_ok_q;
	logic                mp_q;
	logic                up_q;
	logic [1:0]          status_q;
	logic [PB-1:0]       rp_q;
	ffea_pkg::rsp_t      result_q;
	logic                done_q;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	ffea_pkg::entry_t    ram_wdata;
	logic [AW-1:0]       ram_raddr;
	logic [EW-1:0]       ram_rdata;
	ffea_pkg::entry_t    rd;

	logic                accept;
	logic [CB-1:0]       room;
	logic                fit;
	logic                exact;
	logic                mp;
	logic                mn;
	logic [CB-1:0]       prev_end;
	logic [CB-1:0]       new_end;
	logic [CB-1:0]       join_len;
	logic                full;
	logic [SUM_W-1:0]    sum_nx;
	logic [IW-1:0]       idx_m1;

	ffea_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_EXTENTS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(EW'(ram_wdata)),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd     = ffea_pkg::entry_t'(ram_rdata);
	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// room left before the end of the page space
	assign room     = {1'b1, {PB{1'b0}}} - {1'b0, request.page_index};
	assign fit      = (rd.length >= cnt_q);
	assign exact    = (rd.length == cnt_q);
	assign prev_end = {1'b0, prev_q.start} + prev_q.length;
	assign mp       = prev_ok_q && (prev_end == {1'b0, page_q});
	assign new_end  = {1'b0, new_q.start} + new_q.length;
	assign mn       = cur_ok_q && (new_end == {1'b0, cur_q.start});
	assign join_len = new_q.length + cur_q.length;
	assign full     = (used_q == IW'(MAX_EXTENTS));
	assign idx_m1   = idx_q - IW'(1);

	always_comb begin
		if (status_q != ffea_pkg::ST_OK) begin
			sum_nx = sum_q;
		end else if (cmd_q == ffea_pkg::CMD_FREE) begin
			sum_nx = sum_q + SUM_W'(cnt_q);
		end else begin
			sum_nx = sum_q - SUM_W'(cnt_q);
		end
	end

	// table port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q[AW-1:0];
		ram_wdata = new_q;
		ram_raddr = idx_q[AW-1:0];
		case (state_q)
			S_SCAN_CMP: begin
				if (cmd_q == ffea_pkg::CMD_ALLOC && fit && !exact) begin
					ram_we           = 1'b1;
					ram_wdata.start  = rd.start + cnt_q[PB-1:0];
					ram_wdata.length = rd.length - cnt_q;
				end
			end
			S_PLACE: begin
				if (mp_q) begin
					ram_we    = 1'b1;
					ram_waddr = idx_m1[AW-1:0];
					if (mn) begin
						ram_wdata.length = join_len;
					end
				end else if (mn) begin
					ram_we           = 1'b1;
					ram_wdata.length = join_len;
				end
			end
			S_SHIFT_RD: begin
				if (up_q) begin
					ram_raddr = AW'(sidx_q - IW'(1));
					if (sidx_q == idx_q) begin
						ram_we = 1'b1;
					end
				end else begin
					ram_raddr = sidx_q[AW-1:0];
				end
			end
			S_SHIFT_WR: begin
				ram_we    = 1'b1;
				ram_wdata = rd;
				ram_waddr = up_q ? sidx_q[AW-1:0] : AW'(sidx_q - IW'(1));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			used_q   <= '0;
			sum_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q     <= request.command;
						page_q    <= request.page_index;
						idx_q     <= '0;
						prev_ok_q <= 1'b0;
						cur_ok_q  <= 1'b0;
						rp_q      <= '0;
						status_q  <= (request.page_count == '0) ?
						             ffea_pkg::ST_ZERO : ffea_pkg::ST_OK;
						if (request.command == ffea_pkg::CMD_FREE &&
						    request.page_count > room) begin
							cnt_q <= room;
						end else begin
							cnt_q <= request.page_count;
						end
						if (request.page_count == '0) begin
							state_q  <= S_DONE;
						end else begin
							state_q  <= S_SCAN_RD;
						end
					end
				end
				S_SCAN_RD: begin
					if (idx_q == used_q) begin
						if (cmd_q == ffea_pkg::CMD_ALLOC) begin
							status_q <= ffea_pkg::ST_NOFIT;
							state_q  <= S_DONE;
						end else begin
							state_q  <= S_MERGE;
						end
					end else begin
						state_q <= S_SCAN_CMP;
					end
				end
				S_SCAN_CMP: begin
					if (cmd_q == ffea_pkg::CMD_ALLOC) begin
						if (fit) begin
							rp_q <= rd.start;
							if (exact) begin
								up_q    <= 1'b0;
								sidx_q  <= idx_q + IW'(1);
								state_q <= S_SHIFT_RD;
							end else begin
								state_q <= S_DONE;
							end
						end else begin
							idx_q   <= idx_q + IW'(1);
							state_q <= S_SCAN_RD;
						end
					end else if (rd.start >= page_q) begin
						cur_q    <= rd;
						cur_ok_q <= 1'b1;
						state_q  <= S_MERGE;
					end else begin
						prev_q    <= rd;
						prev_ok_q <= 1'b1;
						idx_q     <= idx_q + IW'(1);
						state_q   <= S_SCAN_RD;
					end
				end
				S_MERGE: begin
					mp_q <= mp;
					if (mp) begin
						new_q.start  <= prev_q.start;
						new_q.length <= prev_q.length + cnt_q;
					end else begin
						new_q.start  <= page_q;
						new_q.length <= cnt_q;
					end
					state_q <= S_PLACE;
				end
				S_PLACE: begin
					if (mp_q && mn) begin
						// both neighbors join: drop the successor
						rp_q    <= new_q.start;
						up_q    <= 1'b0;
						sidx_q  <= idx_q + IW'(1);
						state_q <= S_SHIFT_RD;
					end else if (mp_q || mn) begin
						rp_q    <= new_q.start;
						state_q <= S_DONE;
					end else if (full) begin
						status_q <= ffea_pkg::ST_FULL;
						state_q  <= S_DONE;
					end else begin
						rp_q    <= new_q.start;
						up_q    <= 1'b1;
						sidx_q  <= used_q;
						state_q <= S_SHIFT_RD;
					end
				end
				S_SHIFT_RD: begin
					if (up_q && sidx_q == idx_q) begin
						used_q  <= used_q + IW'(1);
						state_q <= S_DONE;
					end else if (!up_q && sidx_q == used_q) begin
						used_q  <= used_q - IW'(1);
						state_q <= S_DONE;
					end else begin
						state_q <= S_SHIFT_WR;
					end
				end
				S_SHIFT_WR: begin
					sidx_q  <= up_q ? sidx_q - IW'(1) : sidx_q + IW'(1);
					state_q <= S_SHIFT_RD;
				end
				S_DONE: begin
					sum_q                <= sum_nx;
					result_q.status      <= status_q;
					result_q.result_page <= rp_q;
					// saturate the reported total
					if (sum_nx > SUM_W'({CB{1'b1}})) begin
						result_q.free_total <= {CB{1'b1}};
					end else begin
						result_q.free_total <= sum_nx[CB-1:0];
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`FFEA_ASSERT_ALWAYS(a_used_bound, used_q <= IW'(MAX_EXTENTS), "extent count above table size")
	`FFEA_ASSERT(a_done_from_seq, done_q |-> $past(state_q == S_DONE), "done without finish step")
	`FFEA_ASSERT(a_accept_busy, accept |=> busy, "request taken but block not busy")
	`FFEA_ASSERT(a_fail_no_page, done_q && result_q.status != ffea_pkg::ST_OK |-> result_q.result_page == '0, "failed request reports a page")
	`FFEA_ASSERT(a_fail_keeps_sum, done_q && result_q.status != ffea_pkg::ST_OK |-> sum_q == $past(sum_q), "failed request changed free total")

endmodule

// ----- src/ffea_ram.sv -----
// generic single write port ram with registered read
module ffea_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
